### rtl/idll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

   localparam int TYPE_W      = 3;
   localparam int POS_W       = 8;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 6;
   localparam int MAX_RESULTS = 32;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUSH_FRONT   = 3'd0,
      REQ_PUSH_BACK    = 3'd1,
      REQ_INSERT_AT    = 3'd2,
      REQ_DELETE_FRONT = 3'd3,
      REQ_DELETE_BACK  = 3'd4,
      REQ_DELETE_AT    = 3'd5,
      REQ_DUMP         = 3'd6
   } req_code_type;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_DUMP,
      OP_BAD
   } op_type;

   // Where in the list an insert or delete lands.
   typedef enum logic [1:0] {
      KIND_SOLE,
      KIND_FRONT,
      KIND_BACK,
      KIND_MID
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_UPD_A,
      ST_UPD_B,
      ST_UPD_C,
      ST_RESP,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic value;
      logic fwd;
      logic bwd;
   } wr_en_type;

endpackage

`default_nettype wire

### rtl/indexed_doubly_linked_list.sv
// Ordered list of signed 32-bit values held as a doubly linked list in a
// slot memory of CAPACITY entries, with a free-slot map for allocation.
// Requests arrive on the req_ channel (req_type, req_position, req_value) and
// are taken one at a time: req_stall is high from acceptance until the last
// result of that item has been loaded into the output register.
// Results leave on the rsp_ channel from a single output register, so a new
// item can be accepted while the final result of the previous one still waits.
// Push front and push back write the new slot without a walk, the front and
// back deletes read only the head or tail slot, and a rejected item goes
// straight to the response. Insert or delete at an index follows the
// forward links from the head one slot per cycle through the single memory
// read port.
// A dump gives one item per cycle while the receiver does not stall, front
// to back, with rsp_last on the final element; an empty list gives one item.
// Reset empties the list and frees every slot at once; memory contents are
// left as they are. When the receiver stalls, the output item holds, and
// the response or dump step waits without losing or repeating anything.
`timescale 1ns / 1ps
`default_nettype none

module indexed_doubly_linked_list
   import idll_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [TYPE_W-1:0]        req_type,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_ok,
   output logic                          rsp_has_data,
   output logic signed [DATA_W-1:0]      rsp_data,
   output logic [COUNT_W-1:0]            rsp_count,
   output logic                          rsp_last
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type                state_ff, state_in;
   logic [TYPE_W-1:0]        type_ff, type_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   op_type                   op_ff, op_in;
   kind_type                 kind_ff, kind_in;
   logic                     ok_ff, ok_in;
   logic [CW-1:0]            target_ff, target_in;
   logic [CW-1:0]            step_ff, step_in;
   logic [SW-1:0]            cur_ff, cur_in;
   logic [SW-1:0]            prev_ff, prev_in;
   logic [SW-1:0]            next_ff, next_in;
   logic [SW-1:0]            n_ff, n_in;
   logic [SW-1:0]            head_ff, head_in;
   logic [SW-1:0]            tail_ff, tail_in;
   logic [CW-1:0]            count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic                     rsp_has_data_ff, rsp_has_data_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   wr_en_type                wr_en;
   logic [SW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_value;
   logic [SW-1:0]            wr_fwd;
   logic [SW-1:0]            wr_bwd;
   logic [SW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_value;
   logic [SW-1:0]            rd_fwd;
   logic [SW-1:0]            rd_bwd;

   logic                     take;
   logic                     give;
   logic [SW-1:0]            give_slot;
   logic [SW-1:0]            free_slot;

   logic                     out_free;

   idll_store #(.DEPTH(CAPACITY)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_fwd   (wr_fwd),
      .wr_bwd   (wr_bwd),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_fwd   (rd_fwd),
      .rd_bwd   (rd_bwd)
   );

   idll_alloc #(.DEPTH(CAPACITY)) u_alloc (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .give      (give),
      .give_slot (give_slot),
      .free_slot (free_slot)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);

   always_comb begin
      op_type           op_v;
      logic [POS_W-1:0] idx_v;
      logic [POS_W-1:0] count8_v;
      logic             load_v;
      logic             ld_ok_v;
      logic             ld_hd_v;
      logic             ld_last_v;

      state_in  = state_ff;
      type_in   = type_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      op_in     = op_ff;
      kind_in   = kind_ff;
      ok_in     = ok_ff;
      target_in = target_ff;
      step_in   = step_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      next_in   = next_ff;
      n_in      = n_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;

      wr_en     = '0;
      wr_addr   = '0;
      wr_value  = val_ff;
      wr_fwd    = '0;
      wr_bwd    = '0;
      rd_addr   = cur_ff;
      take      = 1'b0;
      give      = 1'b0;
      give_slot = cur_ff;

      load_v    = 1'b0;
      ld_ok_v   = 1'b0;
      ld_hd_v   = 1'b0;
      ld_last_v = 1'b1;

      count8_v  = POS_W'(count_ff);
      op_v      = OP_BAD;
      idx_v     = '0;

      unique case (type_ff)
         REQ_PUSH_FRONT: begin
            op_v  = OP_INSERT;
            idx_v = '0;
         end
         REQ_PUSH_BACK: begin
            op_v  = OP_INSERT;
            idx_v = count8_v;
         end
         REQ_INSERT_AT: begin
            op_v  = OP_INSERT;
            idx_v = pos_ff;
         end
         REQ_DELETE_FRONT: begin
            op_v  = OP_DELETE;
            idx_v = '0;
         end
         REQ_DELETE_BACK: begin
            // On an empty list this wraps, and the range check rejects it.
            op_v  = OP_DELETE;
            idx_v = count8_v - POS_W'(1);
         end
         REQ_DELETE_AT: begin
            op_v  = OP_DELETE;
            idx_v = pos_ff;
         end
         REQ_DUMP: begin
            op_v  = OP_DUMP;
         end
         default: begin
            op_v  = OP_BAD;
         end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in  = req_type;
               pos_in   = req_position;
               val_in   = req_value;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            op_in    = op_v;
            ok_in    = 1'b0;
            step_in  = '0;
            state_in = ST_RESP;
            case (op_v)
               OP_INSERT: begin
                  if (count_ff < CW'(CAPACITY) && idx_v <= count8_v) begin
                     ok_in    = 1'b1;
                     state_in = ST_UPD_A;
                     if (count_ff == '0) begin
                        kind_in = KIND_SOLE;
                     end else if (idx_v == '0) begin
                        kind_in = KIND_FRONT;
                     end else if (idx_v == count8_v) begin
                        kind_in = KIND_BACK;
                     end else begin
                        kind_in   = KIND_MID;
                        target_in = CW'(idx_v);
                        cur_in    = head_ff;
                        rd_addr   = head_ff;
                        state_in  = ST_WALK;
                     end
                  end
               end
               OP_DELETE: begin
                  if (count_ff != '0 && idx_v < count8_v) begin
                     ok_in     = 1'b1;
                     state_in  = ST_WALK;
                     target_in = '0;
                     cur_in    = head_ff;
                     rd_addr   = head_ff;
                     if (count_ff == CW'(1)) begin
                        kind_in = KIND_SOLE;
                     end else if (idx_v == '0) begin
                        kind_in = KIND_FRONT;
                     end else if (idx_v == count8_v - POS_W'(1)) begin
                        // The last element is reached from the tail directly.
                        kind_in = KIND_BACK;
                        cur_in  = tail_ff;
                        rd_addr = tail_ff;
                     end else begin
                        kind_in   = KIND_MID;
                        target_in = CW'(idx_v);
                     end
                  end
               end
               OP_DUMP: begin
                  ok_in = 1'b1;
                  if (count_ff != '0) begin
                     cur_in   = head_ff;
                     rd_addr  = head_ff;
                     state_in = ST_DUMP;
                     if (count8_v > POS_W'(MAX_RESULTS)) begin
                        target_in = CW'(MAX_RESULTS - 1);
                     end else begin
                        target_in = count_ff - CW'(1);
                     end
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end

         ST_WALK: begin
            // Read data here always belongs to the slot held in cur_ff.
            if (step_ff == target_ff) begin
               prev_in  = rd_bwd;
               next_in  = rd_fwd;
               state_in = ST_UPD_A;
            end else begin
               cur_in  = rd_fwd;
               rd_addr = rd_fwd;
               step_in = step_ff + CW'(1);
            end
         end

         ST_UPD_A: begin
            state_in = ST_UPD_B;
            if (op_ff == OP_INSERT) begin
               take     = 1'b1;
               n_in     = free_slot;
               wr_en    = '{value: 1'b1, fwd: 1'b1, bwd: 1'b1};
               wr_addr  = free_slot;
               if (kind_ff == KIND_FRONT) begin
                  wr_fwd = head_ff;
               end else if (kind_ff == KIND_MID) begin
                  wr_fwd = cur_ff;
               end
               if (kind_ff == KIND_BACK) begin
                  wr_bwd = tail_ff;
               end else if (kind_ff == KIND_MID) begin
                  wr_bwd = prev_ff;
               end
            end else begin
               give = 1'b1;
               case (kind_ff)
                  KIND_FRONT: begin
                     wr_en   = '{value: 1'b0, fwd: 1'b0, bwd: 1'b1};
                     wr_addr = next_ff;
                  end
                  KIND_BACK: begin
                     wr_en   = '{value: 1'b0, fwd: 1'b1, bwd: 1'b0};
                     wr_addr = prev_ff;
                  end
                  KIND_MID: begin
                     wr_en   = '{value: 1'b0, fwd: 1'b1, bwd: 1'b0};
                     wr_addr = prev_ff;
                     wr_fwd  = next_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_UPD_B: begin
            state_in = ST_UPD_C;
            if (op_ff == OP_INSERT) begin
               case (kind_ff)
                  KIND_FRONT: begin
                     wr_en   = '{value: 1'b0, fwd: 1'b0, bwd: 1'b1};
                     wr_addr = head_ff;
                     wr_bwd  = n_ff;
                  end
                  KIND_BACK: begin
                     wr_en   = '{value: 1'b0, fwd: 1'b1, bwd: 1'b0};
                     wr_addr = tail_ff;
                     wr_fwd  = n_ff;
                  end
                  KIND_MID: begin
                     wr_en   = '{value: 1'b0, fwd: 1'b1, bwd: 1'b0};
                     wr_addr = prev_ff;
                     wr_fwd  = n_ff;
                  end
                  default: begin
                  end
               endcase
            end else if (kind_ff == KIND_MID) begin
               wr_en   = '{value: 1'b0, fwd: 1'b0, bwd: 1'b1};
               wr_addr = next_ff;
               wr_bwd  = prev_ff;
            end
         end

         ST_UPD_C: begin
            state_in = ST_RESP;
            if (op_ff == OP_INSERT && kind_ff == KIND_MID) begin
               wr_en   = '{value: 1'b0, fwd: 1'b0, bwd: 1'b1};
               wr_addr = cur_ff;
               wr_bwd  = n_ff;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               load_v   = 1'b1;
               ld_ok_v  = ok_ff;
               state_in = ST_IDLE;
               if (ok_ff && op_ff == OP_INSERT) begin
                  count_in = count_ff + CW'(1);
                  if (kind_ff == KIND_SOLE || kind_ff == KIND_FRONT) begin
                     head_in = n_ff;
                  end
                  if (kind_ff == KIND_SOLE || kind_ff == KIND_BACK) begin
                     tail_in = n_ff;
                  end
               end else if (ok_ff && op_ff == OP_DELETE) begin
                  count_in = count_ff - CW'(1);
                  case (kind_ff)
                     KIND_SOLE: begin
                        head_in = '0;
                        tail_in = '0;
                     end
                     KIND_FRONT: begin
                        head_in = next_ff;
                     end
                     KIND_BACK: begin
                        tail_in = prev_ff;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         ST_DUMP: begin
            if (out_free) begin
               load_v    = 1'b1;
               ld_ok_v   = 1'b1;
               ld_hd_v   = 1'b1;
               ld_last_v = (step_ff == target_ff);
               if (step_ff == target_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_in  = rd_fwd;
                  rd_addr = rd_fwd;
                  step_in = step_ff + CW'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_ok_in       = rsp_ok_ff;
      rsp_has_data_in = rsp_has_data_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_last_in     = rsp_last_ff;
      if (load_v) begin
         rsp_valid_in    = 1'b1;
         rsp_ok_in       = ld_ok_v;
         rsp_has_data_in = ld_hd_v;
         rsp_data_in     = ld_hd_v ? rd_value : '0;
         rsp_count_in    = COUNT_W'(count_in);
         rsp_last_in     = ld_last_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff         <= type_in;
      pos_ff          <= pos_in;
      val_ff          <= val_in;
      op_ff           <= op_in;
      kind_ff         <= kind_in;
      ok_ff           <= ok_in;
      target_ff       <= target_in;
      step_ff         <= step_in;
      cur_ff          <= cur_in;
      prev_ff         <= prev_in;
      next_ff         <= next_in;
      n_ff            <= n_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_has_data_ff <= rsp_has_data_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_has_data = rsp_has_data_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_last     = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      (wr_en != '0) |->
         (state_ff == ST_UPD_A || state_ff == ST_UPD_B || state_ff == ST_UPD_C))
      else $error("memory written outside the update steps");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK || state_ff == ST_DUMP) |-> step_ff <= target_ff)
      else $error("link walk ran past its target");

endmodule

`default_nettype wire

### rtl/idll_store.sv
`timescale 1ns / 1ps
`default_nettype none

module idll_store
   import idll_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire wr_en_type                  wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic signed [DATA_W-1:0]   wr_value,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_fwd,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_bwd,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [DATA_W-1:0]        rd_value,
   output logic [$clog2(DEPTH)-1:0]        rd_fwd,
   output logic [$clog2(DEPTH)-1:0]        rd_bwd
);

   localparam int SW = $clog2(DEPTH);

   logic signed [DATA_W-1:0] value_mem [DEPTH];
   logic [SW-1:0]            fwd_mem   [DEPTH];
   logic [SW-1:0]            bwd_mem   [DEPTH];

   logic signed [DATA_W-1:0] rd_value_ff;
   logic [SW-1:0]            rd_fwd_ff;
   logic [SW-1:0]            rd_bwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en.value) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_en.fwd) begin
         fwd_mem[wr_addr] <= wr_fwd;
      end
      if (wr_en.bwd) begin
         bwd_mem[wr_addr] <= wr_bwd;
      end
   end

   always_ff @(posedge clock) begin
      rd_value_ff <= value_mem[rd_addr];
      rd_fwd_ff   <= fwd_mem[rd_addr];
      rd_bwd_ff   <= bwd_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_fwd   = rd_fwd_ff;
   assign rd_bwd   = rd_bwd_ff;

endmodule

`default_nettype wire

### rtl/idll_alloc.sv
`timescale 1ns / 1ps
`default_nettype none

module idll_alloc
   import idll_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      take,
   input  wire logic                      give,
   input  wire logic [$clog2(DEPTH)-1:0]  give_slot,
   output logic [$clog2(DEPTH)-1:0]       free_slot
);

   localparam int SW = $clog2(DEPTH);

   logic [DEPTH-1:0] map_ff;
   logic [DEPTH-1:0] map_in;

   // Lowest free slot wins.
   always_comb begin
      free_slot = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   always_comb begin
      map_in = map_ff;
      if (take) begin
         map_in[free_slot] = 1'b0;
      end
      if (give) begin
         map_in[give_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '1;
      end else begin
         map_ff <= map_in;
      end
   end

   a_take_free: assert property (@(posedge clock) disable iff (reset)
      take |-> map_ff[free_slot])
      else $error("slot taken from a full map");

   a_give_used: assert property (@(posedge clock) disable iff (reset)
      give |-> !map_ff[give_slot])
      else $error("slot released that was already free");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(take && give))
      else $error("take and release in the same cycle");

endmodule

`default_nettype wire
